>>> rtl/core/ric_pkg.sv
// Shared constants for the Coleman-Liau readability index counter.
package ric_pkg;

    // ASCII codes of interest
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_TAB     = 8'h09;
    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_PERIOD  = 8'h2E;
    localparam logic [7:0] CHR_QUERY   = 8'h3F;
    localparam logic [7:0] CHR_BANG    = 8'h21;

    // Index scaled by 100*W: 588*L - 2960*S - 1580*W over 100*W
    localparam int LETTER_WEIGHT   = 588;
    localparam int SENTENCE_WEIGHT = 2960;
    localparam int WORD_WEIGHT     = 1580;
    localparam int WORD_STEP       = 100;

    // Grade class boundaries and codes
    localparam logic signed [15:0] GRADE_LOW_MAX  = 16'sd1;
    localparam logic signed [15:0] GRADE_HIGH_MIN = 16'sd16;

    typedef enum logic [1:0] {
        CLASS_LOW  = 2'd0,
        CLASS_MID  = 2'd1,
        CLASS_HIGH = 2'd2
    } grade_class_t;

endpackage

>>> rtl/core/readability_index_counter.sv
// Top level: byte-stream letter/word/sentence counter with Coleman-Liau index output.
//
// Each non-final byte only updates the counts and two running sums (the scaled
// numerator and 100*W), so no multiplier is needed. The final byte starts the
// index calculation: S_PREP takes the magnitude, then a restoring divider
// produces one quotient bit per cycle, NW bits in all (NW =
// clog2(9180*MAX_COUNT+1), 30 for the default), then S_DONE saturates, classifies
// and loads the output register; in_stall is high after the final byte is taken
// until that load. The result waits in its output register; the next text may
// stream in while it does, and the block only holds at the end of that text if
// the previous result has still not been taken.
module readability_index_counter #(
    parameter int unsigned MAX_COUNT = 65536
) (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 text_byte,
    input  logic                       last_byte,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [15:0]         grade_index,
    output ric_pkg::grade_class_t      grade_class,
    output logic [16:0]                letter_total,
    output logic [16:0]                word_total,
    output logic [16:0]                sentence_total
);

    import ric_pkg::*;

    localparam int CW    = $clog2(64'(MAX_COUNT) + 64'd1);
    localparam int NUMW  = $clog2(64'(MAX_COUNT) * 64'd4540 + 64'd1) + 1;
    localparam int DENW  = $clog2(64'(MAX_COUNT) * 64'd100 + 64'd1);
    localparam int NW    = $clog2(64'(MAX_COUNT) * 64'd9180 + 64'd1);
    localparam int DW    = DENW + 1;
    localparam int SW    = $clog2(NW);

    localparam logic [CW-1:0]          CNT_MAX  = CW'(MAX_COUNT);
    localparam logic signed [NUMW-1:0] NUM_INIT = -(NUMW'(WORD_WEIGHT));
    localparam logic [DENW-1:0]        DEN_INIT = DENW'(WORD_STEP);
    localparam logic [SW-1:0]          STEP_TOP = SW'(NW - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            letter_reg, letter_next;
    logic [CW-1:0]            word_reg, word_next;
    logic [CW-1:0]            sentence_reg, sentence_next;
    logic signed [NUMW-1:0]   num_reg, num_next;
    logic [DENW-1:0]          den_reg, den_next;
    logic                     neg_reg, neg_next;
    logic [NW-1:0]            quo_reg, quo_next;
    logic [DW-1:0]            rem_reg, rem_next;
    logic [DW-1:0]            div_reg, div_next;
    logic [SW-1:0]            step_reg, step_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [15:0]       index_reg, index_next;
    grade_class_t             class_reg, class_next;
    logic [16:0]              ltot_reg, ltot_next;
    logic [16:0]              wtot_reg, wtot_next;
    logic [16:0]              stot_reg, stot_next;

    logic                     accept;
    logic                     is_letter;
    logic                     is_space;
    logic                     is_stop;
    logic [NUMW-1:0]          mag;
    logic [DW:0]              trial;
    logic                     trial_ge;
    logic                     load_out;
    logic signed [15:0]       index_sat;

    assign in_stall       = (state_reg != S_IDLE);
    assign accept         = in_valid && !in_stall;
    assign out_valid      = out_valid_reg;
    assign grade_index    = index_reg;
    assign grade_class    = class_reg;
    assign letter_total   = ltot_reg;
    assign word_total     = wtot_reg;
    assign sentence_total = stot_reg;

    assign is_letter = (text_byte >= CHR_UPPER_A && text_byte <= CHR_UPPER_Z) ||
                       (text_byte >= CHR_LOWER_A && text_byte <= CHR_LOWER_Z);
    assign is_space  = (text_byte == CHR_SPACE) ||
                       (text_byte >= CHR_TAB && text_byte <= CHR_CR);
    assign is_stop   = (text_byte == CHR_PERIOD) || (text_byte == CHR_QUERY) ||
                       (text_byte == CHR_BANG);

    assign mag      = num_reg[NUMW-1] ? NUMW'(-num_reg) : NUMW'(num_reg);
    assign trial    = {rem_reg, quo_reg[NW-1]};
    assign trial_ge = (trial >= {1'b0, div_reg});
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // round-half-away quotient is already in quo_reg; clamp to 16 bits
    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > NW'(32768))
                index_sat = 16'sh8000;
            else
                index_sat = 16'(-quo_reg);
        end
        else
        begin
            if (quo_reg > NW'(32767))
                index_sat = 16'sh7FFF;
            else
                index_sat = quo_reg[15:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        letter_next    = letter_reg;
        word_next      = word_reg;
        sentence_next  = sentence_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        index_next     = index_reg;
        class_next     = class_reg;
        ltot_next      = ltot_reg;
        wtot_next      = wtot_reg;
        stot_next      = stot_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // sums move only when the matching count actually moves
                    if (is_letter && letter_reg < CNT_MAX)
                    begin
                        letter_next = letter_reg + 1'b1;
                        num_next    = num_reg + NUMW'(LETTER_WEIGHT);
                    end
                    else if (is_space && word_reg < CNT_MAX)
                    begin
                        word_next = word_reg + 1'b1;
                        num_next  = num_reg - NUMW'(WORD_WEIGHT);
                        den_next  = den_reg + DENW'(WORD_STEP);
                    end
                    else if (is_stop && sentence_reg < CNT_MAX)
                    begin
                        sentence_next = sentence_reg + 1'b1;
                        num_next      = num_reg - NUMW'(SENTENCE_WEIGHT);
                    end
                    if (last_byte)
                        state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                // (2|num| + den) / (2 den) rounds half away from zero
                neg_next   = num_reg[NUMW-1];
                quo_next   = NW'({mag, 1'b0}) + NW'(den_reg);
                div_next   = {den_reg, 1'b0};
                rem_next   = '0;
                step_next  = STEP_TOP;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (trial_ge)
                    rem_next = DW'(trial - {1'b0, div_reg});
                else
                    rem_next = DW'(trial);
                quo_next = {quo_reg[NW-2:0], trial_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    index_next     = index_sat;
                    if (index_sat <= GRADE_LOW_MAX)
                        class_next = CLASS_LOW;
                    else if (index_sat >= GRADE_HIGH_MIN)
                        class_next = CLASS_HIGH;
                    else
                        class_next = CLASS_MID;
                    ltot_next     = 17'(letter_reg);
                    wtot_next     = 17'(word_reg);
                    stot_next     = 17'(sentence_reg);
                    letter_next   = '0;
                    word_next     = CW'(1);
                    sentence_next = '0;
                    num_next      = NUM_INIT;
                    den_next      = DEN_INIT;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            letter_reg    <= '0;
            word_reg      <= CW'(1);
            sentence_reg  <= '0;
            num_reg       <= NUM_INIT;
            den_reg       <= DEN_INIT;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            div_reg       <= '0;
            index_reg     <= '0;
            class_reg     <= CLASS_LOW;
            ltot_reg      <= '0;
            wtot_reg      <= '0;
            stot_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            letter_reg    <= letter_next;
            word_reg      <= word_next;
            sentence_reg  <= sentence_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            div_reg       <= div_next;
            index_reg     <= index_next;
            class_reg     <= class_next;
            ltot_reg      <= ltot_next;
            wtot_reg      <= wtot_next;
            stot_reg      <= stot_next;
        end
    end

    // running denominator tracks the word count
    a_den_tracks_words: assert property (@(posedge clk) disable iff (!rst_n)
        den_reg == DENW'(WORD_STEP * word_reg))
        else $error("denominator sum out of step with word count");

    // restoring divider keeps its partial remainder below the divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    // a result is only raised by the final stage
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the final stage");

    // counts are back at their start values once a result is loaded
    a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (letter_reg == '0 && word_reg == CW'(1) && sentence_reg == '0))
        else $error("counts not cleared after result");

    // no new byte is taken while the index is being worked out
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> in_stall)
        else $error("input open during division");

endmodule
